@@ rtl/clbr_pkg.sv @@
// Package with the command codes, microcode word type and program ROM of the LCD buffer.
`timescale 1ns / 1ps
`default_nettype none

package clbr_pkg;

  // Command codes carried on the input tuser.
  typedef enum logic [2:0] {
    CMD_STORE   = 3'd0,
    CMD_REFRESH = 3'd1,
    CMD_RAW_INS = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_RAW_DAT = 3'd4
  } cmd_t;

  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] SET_ADDR   = 8'h80;
  localparam int         PC_W       = 5;

  // Source that loads the byte register, together with its final-nibble flag.
  typedef enum logic [1:0] {
    B_NONE = 2'd0,
    B_CODE = 2'd1,
    B_ADDR = 2'd2,
    B_MEM  = 2'd3
  } byte_src_t;

  // Nibble that a step places in the output register.
  typedef enum logic [1:0] {
    E_NONE = 2'd0,
    E_HI   = 2'd1,
    E_LO   = 2'd2
  } emit_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_NOT_ACC     = 4'd2,
    C_IS_STORE    = 4'd3,
    C_IS_CLEAR    = 4'd4,
    C_IS_RAW_INS  = 4'd5,
    C_IS_RAW_DAT  = 4'd6,
    C_NOT_REFRESH = 4'd7,
    C_OUT_RANGE   = 4'd8,
    C_FIN         = 4'd9
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  // Program addresses.
  localparam pc_t P_FETCH   = 5'd0;
  localparam pc_t P_REFRESH = 5'd6;
  localparam pc_t P_EMIT    = 5'd7;
  localparam pc_t P_READ    = 5'd9;
  localparam pc_t P_RAW_INS = 5'd14;
  localparam pc_t P_RAW_DAT = 5'd15;
  localparam pc_t P_STORE   = 5'd16;
  localparam pc_t P_CLEAR   = 5'd17;

  typedef struct packed {
    logic      ready;
    byte_src_t byte_src;
    logic      rs;
    emit_t     emit;
    logic      rd;
    logic      wr;
    logic      clr;
    logic      inc;
    cond_t     cond;
    pc_t       target;
  } uword_t;

  // Builds one control word.
  function automatic uword_t uw(input logic ready, input byte_src_t bs, input logic rs,
                                input emit_t em, input logic rd, input logic wr,
                                input logic clr, input logic inc, input cond_t cond,
                                input pc_t target);
    uword_t w;
    w.ready    = ready;
    w.byte_src = bs;
    w.rs       = rs;
    w.emit     = em;
    w.rd       = rd;
    w.wr       = wr;
    w.clr      = clr;
    w.inc      = inc;
    w.cond     = cond;
    w.target   = target;
    return w;
  endfunction

  // The control program. Steps that are not listed fall back to fetch.
  function automatic uword_t urom(input pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:  w = uw(1'b1, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_NOT_ACC, P_FETCH);
      5'd1:  w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_IS_STORE, P_STORE);
      5'd2:  w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_IS_CLEAR, P_CLEAR);
      5'd3:  w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_IS_RAW_INS,
                    P_RAW_INS);
      5'd4:  w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_IS_RAW_DAT,
                    P_RAW_DAT);
      5'd5:  w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_NOT_REFRESH,
                    P_FETCH);
      // Refresh: set-address instruction first.
      5'd6:  w = uw(1'b0, B_ADDR, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_OUT_RANGE, P_FETCH);
      5'd7:  w = uw(1'b0, B_NONE, 1'b0, E_HI, 1'b0, 1'b0, 1'b0, 1'b0, C_NEVER, P_FETCH);
      5'd8:  w = uw(1'b0, B_NONE, 1'b0, E_LO, 1'b0, 1'b0, 1'b0, 1'b0, C_FIN, P_FETCH);
      // Character loop.
      5'd9:  w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b1, 1'b0, 1'b0, 1'b0, C_NEVER, P_FETCH);
      5'd10: w = uw(1'b0, B_MEM, 1'b1, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_NEVER, P_FETCH);
      5'd11: w = uw(1'b0, B_NONE, 1'b0, E_HI, 1'b0, 1'b0, 1'b0, 1'b0, C_NEVER, P_FETCH);
      5'd12: w = uw(1'b0, B_NONE, 1'b0, E_LO, 1'b0, 1'b0, 1'b0, 1'b0, C_FIN, P_FETCH);
      5'd13: w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b1, C_ALWAYS, P_READ);
      // Raw bytes share the nibble steps of the refresh.
      5'd14: w = uw(1'b0, B_CODE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS, P_EMIT);
      5'd15: w = uw(1'b0, B_CODE, 1'b1, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS, P_EMIT);
      5'd16: w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b1, 1'b0, 1'b0, C_ALWAYS, P_FETCH);
      5'd17: w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b1, 1'b0, C_ALWAYS, P_FETCH);
      default: w = uw(1'b0, B_NONE, 1'b0, E_NONE, 1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS, P_FETCH);
    endcase
    return w;
  endfunction

  // Display address of the first cell of a line.
  function automatic logic [6:0] row_base(input logic [1:0] line);
    logic [6:0] b;
    unique case (line)
      2'd0:    b = 7'h00;
      2'd1:    b = 7'h40;
      2'd2:    b = 7'd20;
      default: b = 7'h54;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/char_lcd_buffer_refresh_4bit.sv @@
// Top level: microcoded character LCD buffer driving a 4-bit bus as a nibble stream.
// A store writes the addressed cell and a clear empties the store; an unknown command does nothing.
// A raw instruction or raw data byte leaves as its high nibble and then its low nibble.
// A refresh sends the set-address byte as two nibbles, then reads, loads and sends each character,
// driven by the sequencer (one step per cycle when not stalled) and the registered read of the store.
// One command at a time; output stalls hold the step counter. Reset empties the output, blanks cells.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_buffer_refresh_4bit
  import clbr_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // line[1:0], column[6:2], end_column[11:7], char_code[19:12]
  input  wire logic [2:0]  s_tuser,  // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // nibble[3:0]
  output logic             m_tuser,  // reg_select
  output logic             m_tlast   // last
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [2:0] ROWS_L = 3'(ROWS);
  localparam logic [4:0] COLS_L = 5'(COLS);
  localparam logic [4:0] LAST_COL = 5'(COLS - 1);

  // Sequencer and datapath registers.
  pc_t         pc;
  pc_t         pc_next;
  uword_t      cw;
  logic [2:0]  cmd_r;
  logic [1:0]  line_r;
  logic [4:0]  cur_col;
  logic [4:0]  endc_r;
  logic [7:0]  code_r;
  logic [7:0]  byte_r;
  logic        rs_r;
  logic        fin_r;
  logic        accept;
  logic        out_free;
  logic        stall;
  logic        in_range;
  logic        jump;
  logic [4:0]  end_col;
  logic [ADDR_W-1:0] addr;

  // Text store with a valid bit per cell; an unwritten cell reads as a space.
  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       rd_data;
  logic             rd_vld;

  assign cw       = urom(pc);
  assign s_tready = cw.ready;
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign stall    = (cw.emit != E_NONE) && !out_free;
  assign in_range = ({1'b0, line_r} < ROWS_L) && (cur_col < COLS_L);
  assign end_col  = (s_tdata[11:7] >= COLS_L) ? LAST_COL : s_tdata[11:7];
  assign addr     = ADDR_W'(line_r) * ADDR_W'(COLS) + ADDR_W'(cur_col);

  // Jump condition decode.
  always_comb begin
    unique case (cw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NOT_ACC:     jump = !accept;
      C_IS_STORE:    jump = (cmd_r == CMD_STORE);
      C_IS_CLEAR:    jump = (cmd_r == CMD_CLEAR);
      C_IS_RAW_INS:  jump = (cmd_r == CMD_RAW_INS);
      C_IS_RAW_DAT:  jump = (cmd_r == CMD_RAW_DAT);
      C_NOT_REFRESH: jump = (cmd_r != CMD_REFRESH);
      C_OUT_RANGE:   jump = !in_range;
      C_FIN:         jump = fin_r;
      default:       jump = 1'b1;
    endcase
  end

  // Step counter: hold while an emitting step finds the output register full, else jump or advance.
  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // Command capture and column counter.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= s_tuser;
      line_r  <= s_tdata[1:0];
      cur_col <= s_tdata[6:2];
      endc_r  <= end_col;
      code_r  <= s_tdata[19:12];
    end else if (cw.inc) begin
      cur_col <= cur_col + 5'd1;
    end
  end

  // Byte register with its register-select and final flags.
  always_ff @(posedge clk) begin
    case (cw.byte_src)
      B_CODE: begin
        byte_r <= code_r;
        rs_r   <= cw.rs;
        fin_r  <= 1'b1;
      end
      B_ADDR: begin
        byte_r <= SET_ADDR | (8'(row_base(line_r)) + 8'(cur_col));
        rs_r   <= cw.rs;
        fin_r  <= (endc_r < cur_col);
      end
      B_MEM: begin
        byte_r <= rd_vld ? rd_data : SPACE_CODE;
        rs_r   <= cw.rs;
        fin_r  <= (cur_col == endc_r);
      end
      default: begin
      end
    endcase
  end

  // Store writes and reads.
  always_ff @(posedge clk) begin
    if (cw.wr && in_range) begin
      mem[addr] <= code_r;
    end
    if (cw.rd) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cw.clr) begin
      vld <= '0;
    end else if (cw.wr && in_range) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.rd) begin
      rd_vld <= vld[addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cw.emit != E_NONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      unique case (cw.emit)
        E_HI: begin
          m_tdata <= {4'b0000, byte_r[7:4]};
          m_tuser <= rs_r;
          m_tlast <= 1'b0;
        end
        E_LO: begin
          m_tdata <= {4'b0000, byte_r[3:0]};
          m_tuser <= rs_r;
          m_tlast <= fin_r;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/clbr_checker.sv @@
// Port-level checker for the LCD buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module clbr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tuser,
  input wire logic       m_tlast
);

  // A stalled output item holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  // Only one command is taken at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // While waiting for a command, only the closing nibble of the previous one may be pending.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("non-final nibble pending while idle");

  // The upper half of the output data is padding.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'b0000)
    else $error("output padding not zero");

endmodule

bind char_lcd_buffer_refresh_4bit clbr_checker u_clbr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

@@ test/char_lcd_buffer_refresh_4bit_test.sv @@
// Self-checking testbench for the character LCD buffer: directed table and random commands.
`timescale 1ns / 1ps

module char_lcd_buffer_refresh_4bit_test;
  import clbr_pkg::*;

  localparam int TEXT_ROWS   = 4;
  localparam int TEXT_COLS   = 20;
  localparam int SCRIPT_N    = 24;
  localparam int RANDOM_N    = 440;
  localparam int PAUSE_AT    = 230;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 150;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 20;
  localparam int PREDICT     = -1;

  // Command codes that the block does not know.
  localparam logic [2:0] CMD_RSVD_A = 3'd5;
  localparam logic [2:0] CMD_RSVD_B = 3'd6;
  localparam logic [2:0] CMD_RSVD_C = 3'd7;

  // One nibble as it leaves the block.
  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } lcd_nibble_t;

  localparam lcd_nibble_t NO_NIB = '0;

  // One command of the stimulus, with the nibbles typed in where they are obvious.
  typedef struct packed {
    logic [2:0]             cmd;
    logic [1:0]             line;
    logic [4:0]             col;
    logic [4:0]             endc;
    logic [7:0]             code;
    logic                   typed;
    logic [2:0]             n_typed;
    lcd_nibble_t [3:0]      typed_nib;
  } lcd_command_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  logic [7:0]   lcd_text [TEXT_ROWS*TEXT_COLS];
  lcd_nibble_t  pending_nibbles [$];
  lcd_command_t script [SCRIPT_N];
  lcd_nibble_t  want_nib;
  int           fault_count;
  int           quiet_cycles;
  int           send_calm;
  int           recv_calm;
  int           nibbles_seen;

  char_lcd_buffer_refresh_4bit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic lcd_nibble_t nb(input logic rs, input logic [3:0] nib, input logic last);
    lcd_nibble_t n;
    n.rs   = rs;
    n.nib  = nib;
    n.last = last;
    return n;
  endfunction

  function automatic lcd_command_t row(input logic [2:0] cmd, input logic [1:0] ln,
                                       input logic [4:0] cl, input logic [4:0] ec,
                                       input logic [7:0] cd, input int n,
                                       input lcd_nibble_t e0, input lcd_nibble_t e1,
                                       input lcd_nibble_t e2, input lcd_nibble_t e3);
    lcd_command_t r;
    r.cmd          = cmd;
    r.line         = ln;
    r.col          = cl;
    r.endc         = ec;
    r.code         = cd;
    r.typed        = (n >= 0);
    r.n_typed      = (n >= 0) ? n[2:0] : 3'd0;
    r.typed_nib[0] = e0;
    r.typed_nib[1] = e1;
    r.typed_nib[2] = e2;
    r.typed_nib[3] = e3;
    return r;
  endfunction

  // Display address of the first cell of each line.
  function automatic logic [7:0] line_address(input logic [1:0] ln);
    logic [7:0] a;
    case (ln)
      2'd0:    a = 8'h00;
      2'd1:    a = 8'h40;
      2'd2:    a = 8'd20;
      default: a = 8'h40 + 8'd20;
    endcase
    return a;
  endfunction

  // A byte leaves as its high nibble and then its low nibble.
  function automatic void queue_byte(input logic rs, input logic [7:0] b, input logic fin,
                                     input bit keep);
    if (keep) begin
      pending_nibbles.push_back(nb(rs, b[7:4], 1'b0));
      pending_nibbles.push_back(nb(rs, b[3:0], fin));
    end
  endfunction

  // Applies one command to the text store and queues the nibbles it sends.
  function automatic void lcd_apply(input lcd_command_t r, input bit keep);
    int         stop;
    int         c;
    logic [7:0] addr;
    case (r.cmd)
      CMD_STORE: begin
        if (r.line < TEXT_ROWS && r.col < TEXT_COLS) lcd_text[r.line*TEXT_COLS + r.col] = r.code;
      end
      CMD_CLEAR: begin
        for (c = 0; c < TEXT_ROWS*TEXT_COLS; c++) lcd_text[c] = SPACE_CODE;
      end
      CMD_RAW_INS: queue_byte(1'b0, r.code, 1'b1, keep);
      CMD_RAW_DAT: queue_byte(1'b1, r.code, 1'b1, keep);
      CMD_REFRESH: begin
        if (r.line < TEXT_ROWS && r.col < TEXT_COLS) begin
          stop = (r.endc >= TEXT_COLS) ? TEXT_COLS - 1 : r.endc;
          addr = SET_ADDR | (line_address(r.line) + r.col);
          queue_byte(1'b0, addr, stop < r.col, keep);
          for (c = r.col; c <= stop; c++) begin
            queue_byte(1'b1, lcd_text[r.line*TEXT_COLS + c], c == stop, keep);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one command, records its nibbles when it is accepted, then waits out the next gap.
  task automatic offer_command(input lcd_command_t r, input bit hold_after);
    int gap;
    int i;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, r.code, r.endc, r.col, r.line};
    s_tuser  <= r.cmd;
    do @(posedge clk); while (!s_tready);
    lcd_apply(r, !r.typed);
    if (r.typed) begin
      for (i = 0; i < r.n_typed; i++) pending_nibbles.push_back(r.typed_nib[i]);
    end
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(10, 40);
    end
    if (hold_after || gap > 0) s_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Stimulus: reset, the directed table, then random commands, then the final verdict.
  initial begin : sender
    lcd_command_t item;
    int           k;
    int           pick;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    fault_count = 0;
    send_calm   = 0;
    for (k = 0; k < TEXT_ROWS*TEXT_COLS; k++) lcd_text[k] = SPACE_CODE;

    // Extremes, every command and the special cases, on a freshly reset store.
    script[0]  = row(CMD_REFRESH, 2'd0, 5'd0, 5'd0, 8'h00, 4,
                     nb(1'b0, 4'h8, 1'b0), nb(1'b0, 4'h0, 1'b0),
                     nb(1'b1, 4'h2, 1'b0), nb(1'b1, 4'h0, 1'b1));
    script[1]  = row(CMD_REFRESH, 2'd3, 5'd19, 5'd19, 8'hFF, 4,
                     nb(1'b0, 4'hE, 1'b0), nb(1'b0, 4'h7, 1'b0),
                     nb(1'b1, 4'h2, 1'b0), nb(1'b1, 4'h0, 1'b1));
    script[2]  = row(CMD_RAW_INS, 2'd0, 5'd0, 5'd0, 8'h00, 2,
                     nb(1'b0, 4'h0, 1'b0), nb(1'b0, 4'h0, 1'b1), NO_NIB, NO_NIB);
    script[3]  = row(CMD_RAW_INS, 2'd3, 5'd31, 5'd31, 8'hFF, 2,
                     nb(1'b0, 4'hF, 1'b0), nb(1'b0, 4'hF, 1'b1), NO_NIB, NO_NIB);
    script[4]  = row(CMD_RAW_DAT, 2'd0, 5'd0, 5'd0, 8'h00, 2,
                     nb(1'b1, 4'h0, 1'b0), nb(1'b1, 4'h0, 1'b1), NO_NIB, NO_NIB);
    script[5]  = row(CMD_RAW_DAT, 2'd3, 5'd31, 5'd31, 8'hFF, 2,
                     nb(1'b1, 4'hF, 1'b0), nb(1'b1, 4'hF, 1'b1), NO_NIB, NO_NIB);
    script[6]  = row(CMD_RAW_INS, 2'd2, 5'd10, 5'd21, 8'h5A, 2,
                     nb(1'b0, 4'h5, 1'b0), nb(1'b0, 4'hA, 1'b1), NO_NIB, NO_NIB);
    script[7]  = row(CMD_STORE, 2'd0, 5'd0, 5'd0, 8'hFF, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[8]  = row(CMD_STORE, 2'd3, 5'd19, 5'd31, 8'h00, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    // A column past the end of the line is ignored by store and refresh alike.
    script[9]  = row(CMD_STORE, 2'd1, 5'd31, 5'd0, 8'h41, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[10] = row(CMD_REFRESH, 2'd1, 5'd25, 5'd19, 8'h00, 0,
                     NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    // An end column past the line is cut to the last column.
    script[11] = row(CMD_REFRESH, 2'd0, 5'd0, 5'd31, 8'h00, PREDICT,
                     NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    // End before start sends the address alone.
    script[12] = row(CMD_REFRESH, 2'd3, 5'd10, 5'd3, 8'h00, 2,
                     nb(1'b0, 4'hD, 1'b0), nb(1'b0, 4'hE, 1'b1), NO_NIB, NO_NIB);
    script[13] = row(CMD_REFRESH, 2'd3, 5'd0, 5'd19, 8'h00, PREDICT,
                     NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[14] = row(CMD_STORE, 2'd2, 5'd5, 5'd0, 8'h5A, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[15] = row(CMD_REFRESH, 2'd2, 5'd5, 5'd5, 8'h00, 4,
                     nb(1'b0, 4'h9, 1'b0), nb(1'b0, 4'h9, 1'b0),
                     nb(1'b1, 4'h5, 1'b0), nb(1'b1, 4'hA, 1'b1));
    // Unknown commands do nothing.
    script[16] = row(CMD_RSVD_A, 2'd3, 5'd31, 5'd31, 8'hFF, 0,
                     NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[17] = row(CMD_RSVD_B, 2'd1, 5'd5, 5'd7, 8'h33, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[18] = row(CMD_RSVD_C, 2'd0, 5'd0, 5'd0, 8'h00, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[19] = row(CMD_CLEAR, 2'd2, 5'd4, 5'd9, 8'hC3, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[20] = row(CMD_REFRESH, 2'd0, 5'd0, 5'd31, 8'h00, PREDICT,
                     NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[21] = row(CMD_REFRESH, 2'd2, 5'd0, 5'd0, 8'h00, 4,
                     nb(1'b0, 4'h9, 1'b0), nb(1'b0, 4'h4, 1'b0),
                     nb(1'b1, 4'h2, 1'b0), nb(1'b1, 4'h0, 1'b1));
    script[22] = row(CMD_STORE, 2'd1, 5'd7, 5'd0, 8'h80, 0, NO_NIB, NO_NIB, NO_NIB, NO_NIB);
    script[23] = row(CMD_REFRESH, 2'd1, 5'd0, 5'd19, 8'h00, PREDICT,
                     NO_NIB, NO_NIB, NO_NIB, NO_NIB);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < SCRIPT_N; k++) offer_command(script[k], k == SCRIPT_N - 1);
    while (pending_nibbles.size() != 0) @(posedge clk);

    // Random commands, mostly in range, with short refresh spans most of the time.
    for (k = 0; k < RANDOM_N; k++) begin
      pick      = $urandom_range(0, 99);
      item      = '0;
      item.line = 2'($urandom_range(0, 3));
      item.col  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31))
                                              : 5'($urandom_range(0, 19));
      item.endc = 5'($urandom_range(0, 31));
      item.code = 8'($urandom_range(0, 255));
      if (pick < 38) begin
        item.cmd = CMD_STORE;
      end else if (pick < 62) begin
        item.cmd = CMD_REFRESH;
        if (item.col < TEXT_COLS && $urandom_range(0, 3) != 0) begin
          item.endc = 5'(item.col + $urandom_range(0, 3));
        end
      end else if (pick < 72) begin
        item.cmd = CMD_RAW_INS;
      end else if (pick < 84) begin
        item.cmd = CMD_RAW_DAT;
      end else if (pick < 87) begin
        item.cmd = CMD_CLEAR;
      end else if (pick < 92) begin
        item.cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
      end else begin
        item.cmd = CMD_REFRESH;
        item.col = 5'($urandom_range(0, 31));
      end
      offer_command(item, k == RANDOM_N - 1 || k == PAUSE_AT);
      // Let the block drain completely once in the middle of the run.
      if (k == PAUSE_AT) begin
        @(posedge clk);
        while (pending_nibbles.size() != 0) @(posedge clk);
      end
    end

    while (pending_nibbles.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_nibbles.size() != 0) begin
      if (fault_count < 10) $display("%0d nibbles never arrived", pending_nibbles.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("char_lcd_buffer_refresh_4bit_test passed");
    end else begin
      $display("char_lcd_buffer_refresh_4bit_test failed");
    end
    $finish;
  end

  // Receiver: random stalls per item, and one long hold that backs the block up.
  initial begin : receiver
    int  gap;
    bit  held;
    m_tready     = 1'b0;
    recv_calm    = 0;
    nibbles_seen = 0;
    held         = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      nibbles_seen++;
      if (!held && nibbles_seen == HOLD_AFTER) begin
        gap  = LONG_HOLD;
        held = 1'b1;
      end else if (recv_calm > 0) begin
        gap = 0;
        recv_calm--;
      end else begin
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 24) == 0) recv_calm = $urandom_range(10, 60);
      end
      if (gap > 0) m_tready <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  end

  // Output check against the oldest expected nibble, and the watchdog on handshakes.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("char_lcd_buffer_refresh_4bit_test failed");
        $finish;
      end else if (m_tvalid && m_tready) begin
        if (pending_nibbles.size() == 0) begin
          if (fault_count < 10) begin
            $display("unexpected item: rs=%0d tdata=%h last=%0d", m_tuser, m_tdata, m_tlast);
          end
          fault_count++;
        end else begin
          want_nib = pending_nibbles.pop_front();
          if (m_tuser !== want_nib.rs || m_tdata !== {4'b0000, want_nib.nib} ||
              m_tlast !== want_nib.last) begin
            if (fault_count < 10) begin
              $display("mismatch: expected rs=%0d nibble=%h last=%0d, got rs=%0d tdata=%h last=%0d",
                       want_nib.rs, want_nib.nib, want_nib.last, m_tuser, m_tdata, m_tlast);
            end
            fault_count++;
          end
        end
      end
    end
  end

endmodule

@@ filelist.f @@
rtl/clbr_pkg.sv
rtl/char_lcd_buffer_refresh_4bit.sv
rtl/clbr_checker.sv
test/char_lcd_buffer_refresh_4bit_test.sv
